/* src/stack_expression_machine_defines.svh */
// Assertion macros for the stack expression machine.
// Used by files that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef STACK_EXPRESSION_MACHINE_DEFINES_SVH
`define STACK_EXPRESSION_MACHINE_DEFINES_SVH

// same-cycle implication
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sem_pkg.sv */
// Shared types and constants for the stack expression machine.
// No dependencies; used by sem_alu and stack_expression_machine.
package sem_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 64;
  localparam int OP_W        = 4;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 72;
  localparam int CNT_W       = $clog2(DATA_W);

  localparam logic [OP_W-1:0] OP_PUSH = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd4;
  localparam logic [OP_W-1:0] OP_EQ   = 4'd5;
  localparam logic [OP_W-1:0] OP_LT   = 4'd6;
  localparam logic [OP_W-1:0] OP_GT   = 4'd7;
  localparam logic [OP_W-1:0] OP_LE   = 4'd8;
  localparam logic [OP_W-1:0] OP_GE   = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_OP    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic              start;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

/* src/sem_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sem_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/sem_alu.sv */
// Iterative arithmetic unit: one shared 65-bit adder for add, sub, compare,
// shift-add multiply and restoring divide. Depends on sem_pkg.
module sem_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  sem_pkg::alu_req_t req,
  output sem_pkg::alu_rsp_t rsp
);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_NEGA = 5'b00010,
    A_NEGB = 5'b00100,
    A_LOOP = 5'b01000,
    A_NEGQ = 5'b10000
  } alu_state_t;

  alu_state_t state_r, state_nxt;
  logic [sem_pkg::DATA_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt, res_r, res_nxt;
  logic [sem_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic neg_r, neg_nxt, div_r, div_nxt, done_r, done_nxt;

  logic [sem_pkg::DATA_W-1:0] add_x, add_y, rem_sh;
  logic                       add_sub, add_sx, lt, eq, qbit;
  logic [sem_pkg::DATA_W:0]   sum;

  assign rem_sh = {x_r[sem_pkg::DATA_W-2:0], z_r[sem_pkg::DATA_W-1]};

  // shared adder operand selection
  always_comb begin
    add_x   = req.a;
    add_y   = req.b;
    add_sub = (req.op != sem_pkg::OP_ADD);
    add_sx  = 1'b1;
    unique case (state_r)
      A_IDLE: begin
      end
      A_NEGA: begin
        add_x = '0; add_y = z_r; add_sub = 1'b1; add_sx = 1'b0;
      end
      A_NEGB: begin
        add_x = '0; add_y = y_r; add_sub = 1'b1; add_sx = 1'b0;
      end
      A_LOOP: begin
        add_x   = div_r ? rem_sh : x_r;
        add_y   = y_r;
        add_sub = div_r;
        add_sx  = 1'b0;
      end
      A_NEGQ: begin
        add_x = '0; add_y = z_r; add_sub = 1'b1; add_sx = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign sum = {add_sx & add_x[sem_pkg::DATA_W-1], add_x}
             + ({add_sx & add_y[sem_pkg::DATA_W-1], add_y} ^ {(sem_pkg::DATA_W+1){add_sub}})
             + {{sem_pkg::DATA_W{1'b0}}, add_sub};
  assign lt   = sum[sem_pkg::DATA_W];
  assign eq   = (req.a == req.b);
  assign qbit = ~sum[sem_pkg::DATA_W];

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    div_nxt   = div_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          priority case (req.op)
            sem_pkg::OP_MUL: begin
              x_nxt     = '0;
              y_nxt     = req.a;
              z_nxt     = req.b;
              cnt_nxt   = '1;
              div_nxt   = 1'b0;
              state_nxt = A_LOOP;
            end
            sem_pkg::OP_DIV: begin
              y_nxt     = req.b;
              z_nxt     = req.a;
              neg_nxt   = req.a[sem_pkg::DATA_W-1] ^ req.b[sem_pkg::DATA_W-1];
              div_nxt   = 1'b1;
              state_nxt = A_NEGA;
            end
            sem_pkg::OP_EQ: begin
              res_nxt = {{(sem_pkg::DATA_W-1){1'b0}}, eq};  done_nxt = 1'b1;
            end
            sem_pkg::OP_LT: begin
              res_nxt = {{(sem_pkg::DATA_W-1){1'b0}}, lt};  done_nxt = 1'b1;
            end
            sem_pkg::OP_GT: begin
              res_nxt = {{(sem_pkg::DATA_W-1){1'b0}}, ~lt & ~eq};  done_nxt = 1'b1;
            end
            sem_pkg::OP_LE: begin
              res_nxt = {{(sem_pkg::DATA_W-1){1'b0}}, lt | eq};  done_nxt = 1'b1;
            end
            sem_pkg::OP_GE: begin
              res_nxt = {{(sem_pkg::DATA_W-1){1'b0}}, ~lt};  done_nxt = 1'b1;
            end
            default: begin
              res_nxt  = sum[sem_pkg::DATA_W-1:0];
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      A_NEGA: begin
        if (z_r[sem_pkg::DATA_W-1]) begin
          z_nxt = sum[sem_pkg::DATA_W-1:0];
        end
        state_nxt = A_NEGB;
      end
      A_NEGB: begin
        if (y_r[sem_pkg::DATA_W-1]) begin
          y_nxt = sum[sem_pkg::DATA_W-1:0];
        end
        x_nxt     = '0;
        cnt_nxt   = '1;
        state_nxt = A_LOOP;
      end
      A_LOOP: begin
        if (div_r) begin
          x_nxt = qbit ? sum[sem_pkg::DATA_W-1:0] : rem_sh;
          z_nxt = {z_r[sem_pkg::DATA_W-2:0], qbit};
        end else begin
          x_nxt = z_r[0] ? sum[sem_pkg::DATA_W-1:0] : x_r;
          y_nxt = {y_r[sem_pkg::DATA_W-2:0], 1'b0};
          z_nxt = {1'b0, z_r[sem_pkg::DATA_W-1:1]};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (div_r) begin
            state_nxt = A_NEGQ;
          end else begin
            res_nxt   = x_nxt;
            done_nxt  = 1'b1;
            state_nxt = A_IDLE;
          end
        end
      end
      A_NEGQ: begin
        res_nxt   = neg_r ? sum[sem_pkg::DATA_W-1:0] : z_r;
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: begin
        state_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    div_r <= div_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

/* src/stack_expression_machine.sv */
// Stack expression machine: sequencer, stack RAM and output register.
// Depends on sem_pkg, sem_ram, sem_alu and stack_expression_machine_defines.svh.
//
// Usage:
//   Input stream: one instruction per transaction. in_tdata carries the
//   opcode and the immediate, in_tlast marks the last instruction of a program.
//   Output stream: one transaction per program, after its last instruction,
//   carrying the bottom stack entry and a status code.
//   Sequencing: the sequencer handles one item at a time; push, underflow,
//   overflow and bad opcode finish in S_DECODE, divide by zero in S_FETCH, and
//   add, sub, compare, multiply and divide wait in S_WAIT for the ALU. The stack
//   RAM read port fetches the lower operand (top of stack is held in a register).
//   A last item then passes through S_DONE to load the output register.
//   While a result waits for out_tready, further items are still taken;
//   only the next last item holds until the output register is free.
//   Reset: synchronous, active low; empties the stack and clears the error.
//   Stack RAM contents are not cleared and need no clearing pass.
`include "stack_expression_machine_defines.svh"

module stack_expression_machine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] operation, [67:4] immediate, [71:68] zero
  input  logic [sem_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [63:0] result_value
  output logic [sem_pkg::DATA_W-1:0]         out_tdata,
  // [2:0] status
  output logic [sem_pkg::STATUS_W-1:0]       out_tuser
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_FETCH  = 5'b00100,
    S_WAIT   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [sem_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [sem_pkg::DATA_W-1:0]   imm_r, imm_nxt, tos_r, tos_nxt, bot_r, bot_nxt;
  logic                         eop_r, eop_nxt;
  logic [sem_pkg::SP_W-1:0]     sp_r, sp_nxt, sp_m1, sp_m2;
  logic [sem_pkg::STATUS_W-1:0] err_r, err_nxt, out_status_r, out_status_nxt;
  logic [sem_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;

  logic                         ram_we, ram_re;
  logic [sem_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [sem_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;

  sem_pkg::alu_req_t alu_req;
  sem_pkg::alu_rsp_t alu_rsp;

  sem_ram #(
    .WIDTH (sem_pkg::DATA_W),
    .DEPTH (sem_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sem_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign sp_m1     = sp_r - 1'b1;
  assign sp_m2     = sp_r - 2'd2;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    imm_nxt        = imm_r;
    eop_nxt        = eop_r;
    sp_nxt         = sp_r;
    err_nxt        = err_r;
    tos_nxt        = tos_r;
    bot_nxt        = bot_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    ram_we         = 1'b0;
    ram_waddr      = sp_r[sem_pkg::ADDR_W-1:0];
    ram_wdata      = imm_r;
    ram_re         = 1'b0;
    ram_raddr      = sp_m2[sem_pkg::ADDR_W-1:0];
    alu_req.start  = 1'b0;
    alu_req.op     = op_r;
    alu_req.a      = ram_rdata;
    alu_req.b      = tos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tdata[sem_pkg::OP_W-1:0];
          imm_nxt   = in_tdata[sem_pkg::OP_W +: sem_pkg::DATA_W];
          eop_nxt   = in_tlast;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = eop_r ? S_DONE : S_IDLE;
        if (err_r == sem_pkg::ST_OK) begin
          priority if (op_r == sem_pkg::OP_PUSH) begin
            if (sp_r == sem_pkg::SP_W'(sem_pkg::STACK_DEPTH)) begin
              err_nxt = sem_pkg::ST_OVERFLOW;
            end else begin
              ram_we  = 1'b1;
              tos_nxt = imm_r;
              if (sp_r == '0) begin
                bot_nxt = imm_r;
              end
              sp_nxt = sp_r + 1'b1;
            end
          end else if (op_r > sem_pkg::OP_GE) begin
            err_nxt = sem_pkg::ST_BAD_OP;
          end else if (sp_r < sem_pkg::SP_W'(2)) begin
            err_nxt = sem_pkg::ST_UNDERFLOW;
          end else begin
            ram_re    = 1'b1;
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        if (op_r == sem_pkg::OP_DIV && tos_r == '0) begin
          err_nxt   = sem_pkg::ST_DIV_ZERO;
          state_nxt = eop_r ? S_DONE : S_IDLE;
        end else begin
          alu_req.start = 1'b1;
          state_nxt     = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          ram_we    = 1'b1;
          ram_waddr = sp_m2[sem_pkg::ADDR_W-1:0];
          ram_wdata = alu_rsp.result;
          tos_nxt   = alu_rsp.result;
          if (sp_r == sem_pkg::SP_W'(2)) begin
            bot_nxt = alu_rsp.result;
          end
          sp_nxt    = sp_m1;
          state_nxt = eop_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          priority if (err_r != sem_pkg::ST_OK) begin
            out_data_nxt   = '0;
            out_status_nxt = err_r;
          end else if (sp_r == '0) begin
            out_data_nxt   = '0;
            out_status_nxt = sem_pkg::ST_EMPTY;
          end else begin
            out_data_nxt   = bot_r;
            out_status_nxt = sem_pkg::ST_OK;
          end
          sp_nxt    = '0;
          err_nxt   = sem_pkg::ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sp_r         <= '0;
      err_r        <= sem_pkg::ST_OK;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sp_r         <= sp_nxt;
      err_r        <= err_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    imm_r        <= imm_nxt;
    eop_r        <= eop_nxt;
    tos_r        <= tos_nxt;
    bot_r        <= bot_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  `SEM_ASSERT_IMPL(a_sp_bound, 1'b1, sp_r <= sem_pkg::SP_W'(sem_pkg::STACK_DEPTH), "sp past depth")
  `SEM_ASSERT_IMPL(a_we_no_err, ram_we, err_r == sem_pkg::ST_OK, "stack write under error")
  `SEM_ASSERT_IMPL(a_fetch_two, state_r == S_FETCH, sp_r >= sem_pkg::SP_W'(2), "fetch underflow")
  `SEM_ASSERT_IMPL(a_alu_done_wait, alu_rsp.done, state_r == S_WAIT, "alu done out of wait")
  `SEM_ASSERT_NEXT(a_end_clears, state_r == S_DONE && (!out_tvalid_r || out_tready), sp_r == '0 && err_r == sem_pkg::ST_OK && out_tvalid_r, "end not cleared")

endmodule

/* verif/stack_expression_machine_test.sv */
// Self-checking testbench for stack_expression_machine: directed programs, then random
// RPN programs with random stalls on both streams, checked against an in-bench stack model.
// Depends on sem_pkg and the stack_expression_machine RTL.
`timescale 1ns / 1ps

module stack_expression_machine_test;
  import sem_pkg::*;

  localparam logic [OP_W-1:0]   OP_FIRST_BAD = 4'd10;
  localparam logic [OP_W-1:0]   OP_LAST_BAD  = 4'd15;
  localparam logic [DATA_W-1:0] S64_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] S64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] S64_NEG_ONE  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int ITEM_TARGET  = 950;
  localparam int QUIET_TAIL   = 100;
  localparam int OVERFLOW_AT  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [DATA_W-1:0]   imm;
    logic                last;
    logic                known;
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } instruction_t;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // model state
  logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
  int                  live_depth = 0;
  logic [STATUS_W-1:0] pending_err = ST_OK;

  outcome_t     results_due [$];
  instruction_t directed_tbl [$];
  int           issued = 0;
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           out_hold = 0;
  bit           quiet = 1'b0;

  always #5 clk = ~clk;

  stack_expression_machine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  task automatic execute_instruction(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] imm,
                                     input logic last, output logic produced,
                                     output outcome_t res);
    logic [DATA_W-1:0] lhs, rhs, quo, val;
    produced = 1'b0;
    res = '0;
    if (pending_err == ST_OK) begin
      if (op == OP_PUSH) begin
        if (live_depth >= STACK_DEPTH) pending_err = ST_OVERFLOW;
        else begin
          stack_mem[live_depth] = imm;
          live_depth++;
        end
      end else if (op > OP_GE) begin
        pending_err = ST_BAD_OP;
      end else if (live_depth < 2) begin
        pending_err = ST_UNDERFLOW;
      end else begin
        lhs = stack_mem[live_depth-2];
        rhs = stack_mem[live_depth-1];
        if (op == OP_DIV && rhs == '0) pending_err = ST_DIV_ZERO;
        else begin
          case (op)
            OP_ADD: val = lhs + rhs;
            OP_SUB: val = lhs - rhs;
            OP_MUL: val = lhs * rhs;
            OP_DIV: begin
              quo = (lhs[DATA_W-1] ? 64'd0 - lhs : lhs) / (rhs[DATA_W-1] ? 64'd0 - rhs : rhs);
              val = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? 64'd0 - quo : quo;
            end
            OP_EQ:  val = {63'd0, lhs == rhs};
            OP_LT:  val = {63'd0, $signed(lhs) < $signed(rhs)};
            OP_GT:  val = {63'd0, $signed(lhs) > $signed(rhs)};
            OP_LE:  val = {63'd0, $signed(lhs) <= $signed(rhs)};
            default: val = {63'd0, $signed(lhs) >= $signed(rhs)};
          endcase
          stack_mem[live_depth-2] = val;
          live_depth--;
        end
      end
    end
    if (last) begin
      produced = 1'b1;
      if (pending_err != ST_OK) res.status = pending_err;
      else if (live_depth == 0) res.status = ST_EMPTY;
      else res.value = stack_mem[0];
      live_depth = 0;
      pending_err = ST_OK;
    end
  endtask

  task automatic issue(input instruction_t ins);
    logic     produced;
    outcome_t res;
    quiet = (issued >= ITEM_TARGET - QUIET_TAIL);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, ins.imm, ins.op};
    in_tlast  <= ins.last;
    do @(posedge clk); while (!in_tready);
    issued++;
    execute_instruction(ins.op, ins.imm, ins.last, produced, res);
    if (produced) begin
      if (ins.known) begin
        res.value  = ins.value;
        res.status = ins.status;
      end
      results_due.push_back(res);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 64'd1;
      2: return S64_NEG_ONE;
      3: return S64_MIN;
      4: return S64_MAX;
      5: return {{56{r[7]}}, r[7:0]};
      default: return {$urandom, r};
    endcase
  endfunction

  function automatic instruction_t rand_ins(input logic [OP_W-1:0] op, input logic last);
    return instruction_t'{op, pick_operand(), last, 1'b0, 64'd0, ST_OK};
  endfunction

  // result stream: stalls and checking
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h status %0d", out_tdata, out_tuser);
      end else begin
        outcome_t exp_res;
        exp_res = results_due.pop_front();
        if (out_tdata !== exp_res.value || out_tuser !== exp_res.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                     exp_res.value, exp_res.status, out_tdata, out_tuser);
        end
      end
    end
    if (quiet) begin
      out_hold = 0;
      out_tready <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold = out_hold - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               kind, len, cap, live;
    bit               overflow_done;
    logic [OP_W-1:0]  op;
    overflow_done = 1'b0;

    directed_tbl.push_back(instruction_t'{OP_ADD, 64'd0, 1'b1, 1'b1, 64'd0, ST_UNDERFLOW});
    directed_tbl.push_back(instruction_t'{OP_PUSH, S64_MIN, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, S64_NEG_ONE, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_DIV, 64'd0, 1'b1, 1'b1, S64_MIN, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, S64_MAX, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, 64'd1, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_ADD, S64_NEG_ONE, 1'b1, 1'b1, S64_MIN, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, 64'd5, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, 64'd0, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_DIV, 64'd0, 1'b1, 1'b1, 64'd0, ST_DIV_ZERO});
    directed_tbl.push_back(instruction_t'{OP_LAST_BAD, S64_MAX, 1'b1, 1'b1, 64'd0, ST_BAD_OP});
    directed_tbl.push_back(instruction_t'{OP_PUSH, -64'sd7, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, 64'd3, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_SUB, 64'd0, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, S64_MAX, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_MUL, 64'd0, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, S64_NEG_ONE, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_LT, 64'd0, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, 64'd1, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_GT, 64'd0, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, 64'd1, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_LE, 64'd0, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, 64'd1, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_GE, 64'd0, 1'b1, 1'b0, 64'd0, ST_OK});
    // error held while later instructions arrive
    directed_tbl.push_back(instruction_t'{OP_FIRST_BAD, 64'd0, 1'b0, 1'b0, 64'd0, ST_OK});
    directed_tbl.push_back(instruction_t'{OP_PUSH, 64'd9, 1'b1, 1'b1, 64'd0, ST_BAD_OP});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_tbl[i]) issue(directed_tbl[i]);

    while (issued < ITEM_TARGET) begin
      if (!overflow_done && issued >= OVERFLOW_AT) begin
        // fill the stack, then one push too many
        repeat (STACK_DEPTH) issue(rand_ins(OP_PUSH, 1'b0));
        issue(rand_ins(OP_PUSH, 1'b0));
        issue(instruction_t'{OP_ADD, pick_operand(), 1'b1, 1'b1, 64'd0, ST_OVERFLOW});
        overflow_done = 1'b1;
      end else begin
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, 24);
        cap  = $urandom_range(2, 12);
        live = 0;
        for (int n = 1; n <= len; n++) begin
          if (kind == 0)
            op = OP_W'($urandom_range(0, 15));
          else if (kind == 1 && n == len / 2 + 1)
            op = $urandom_range(0, 1) ? OP_W'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD))
                                      : OP_W'($urandom_range(OP_ADD, OP_GE));
          else if (live < 2 || (live < cap && $urandom_range(0, 1) == 1))
            op = OP_PUSH;
          else
            op = OP_W'($urandom_range(OP_ADD, OP_GE));
          if (op == OP_PUSH) live++;
          else if (op <= OP_GE && live >= 2) live--;
          issue(rand_ins(op, n == len));
        end
      end
    end
    in_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/sem_pkg.sv
src/sem_ram.sv
src/sem_alu.sv
src/stack_expression_machine.sv
verif/stack_expression_machine_test.sv
